// ===== src/tro_pkg.sv =====
// Shared types and constants for the tachometer rpm / odometer block.
// Used by the top level, the serial divider and the port checker.
package tro_pkg;

    localparam int unsigned RPM_W      = 24;
    localparam int unsigned REV_W      = 32;
    localparam int unsigned DIST_W     = 40;
    localparam int unsigned STEP_W     = 16;
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    localparam int unsigned AVERAGE_WINDOW_DEF = 4;

    // register index, taken from paddr[3:2]
    localparam logic [1:0] REG_TICKS_PER_MINUTE  = 2'd0;
    localparam logic [1:0] REG_TIMEOUT_TICKS     = 2'd1;
    localparam logic [1:0] REG_DISTANCE_PER_EDGE = 2'd2;

    localparam logic [RPM_W-1:0]  TPM_RESET     = 24'd60000;
    localparam logic [RPM_W-1:0]  TIMEOUT_RESET = 24'd2000;
    localparam logic [STEP_W-1:0] DIST_RESET    = 16'd256;

    typedef struct packed {
        logic pin_level;
        logic clear_distance;
    } t_in;

    typedef struct packed {
        logic [RPM_W-1:0]  speed_rpm;
        logic [RPM_W-1:0]  mean_rpm;
        logic [REV_W-1:0]  revolution_count;
        logic [DIST_W-1:0] distance_total;
        logic              rising_seen;
    } t_out;

    typedef enum logic {
        S_IDLE,
        S_DIV
    } t_state;

endpackage

// ===== src/tro_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Depends on tro_pkg for the default width.
module tro_div #(
    parameter int unsigned WIDTH = tro_pkg::RPM_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_done,
    output logic [WIDTH-1:0] o_quotient
);
    import tro_pkg::*;

    localparam int unsigned CNT_W = $clog2(WIDTH);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [WIDTH-1:0] r_rem, n_rem;
    logic [WIDTH-1:0] r_quo, n_quo;
    logic [WIDTH-1:0] r_dvs, n_dvs;

    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   diff;

    always_comb begin
        shifted = {r_rem, r_quo[WIDTH-1]};
        diff    = shifted - {1'b0, r_dvs};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dvs   = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(WIDTH - 1);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            // remainder stays below the divisor, so WIDTH bits hold it
            n_rem = diff[WIDTH] ? shifted[WIDTH-1:0] : diff[WIDTH-1:0];
            n_quo = {r_quo[WIDTH-2:0], ~diff[WIDTH]};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== src/tachometer_rpm_odometer.sv =====
// Top level of the tachometer: edge detect, rpm, window mean and odometer.
// Depends on tro_pkg and tro_div.
//
// One input transfer is one sample tick and yields one result. A tick with no
// rising edge is finished in the cycle it is accepted, so its result is valid
// on the next cycle. A tick with a rising edge runs the rpm division on the
// serial divider, one quotient bit per cycle; the result is written to the
// output register when the divider's done flag rises. Input ready is
// low while the divider runs and while an untaken result sits in the output
// register. Configuration is on an APB port with registers at 0x0, 0x4, 0x8.
module tachometer_rpm_odometer #(
    parameter int unsigned AVERAGE_WINDOW = tro_pkg::AVERAGE_WINDOW_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tro_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tro_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tro_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  tro_pkg::t_in                    i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output tro_pkg::t_out                   o_out_data
);
    import tro_pkg::*;

    localparam int unsigned SUM_W = RPM_W + $clog2(AVERAGE_WINDOW);
    localparam int unsigned PH_W  = $clog2(AVERAGE_WINDOW);
    localparam int unsigned SHIFT = $clog2(AVERAGE_WINDOW + 1) - 1;

    // configuration
    logic [RPM_W-1:0]  r_tpm;
    logic [RPM_W-1:0]  r_timeout;
    logic [STEP_W-1:0] r_step;

    // tick state
    t_state            r_state, n_state;
    logic              r_last, n_last;
    logic [RPM_W-1:0]  r_elapsed, n_elapsed;
    logic [RPM_W-1:0]  r_rpm, n_rpm;
    logic [RPM_W-1:0]  r_mean, n_mean;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [PH_W-1:0]   r_phase, n_phase;
    logic [REV_W-1:0]  r_revs, n_revs;
    logic [DIST_W-1:0] r_odo, n_odo;
    logic              r_to_pend, n_to_pend;
    logic              r_out_valid, n_out_valid;
    t_out              r_out, n_out;

    logic              in_xfer;
    logic              rising;
    logic [RPM_W-1:0]  elapsed_inc;
    logic              timed_out;
    logic              div_start;
    logic              div_done;
    logic [RPM_W-1:0]  div_quo;
    logic [SUM_W-1:0]  sum_add;
    logic [SUM_W-1:0]  sum_shift;
    logic              cfg_wr;

    tro_div #(
        .WIDTH(RPM_W)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(r_tpm),
        .i_divisor (elapsed_inc),
        .o_done    (div_done),
        .o_quotient(div_quo)
    );

    // APB
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[3:2])
            REG_TICKS_PER_MINUTE:  prdata = APB_DATA_W'(r_tpm);
            REG_TIMEOUT_TICKS:     prdata = APB_DATA_W'(r_timeout);
            REG_DISTANCE_PER_EDGE: prdata = APB_DATA_W'(r_step);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpm     <= TPM_RESET;
            r_timeout <= TIMEOUT_RESET;
            r_step    <= DIST_RESET;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_TICKS_PER_MINUTE:  r_tpm     <= pwdata[RPM_W-1:0];
                REG_TIMEOUT_TICKS:     r_timeout <= pwdata[RPM_W-1:0];
                REG_DISTANCE_PER_EDGE: r_step    <= pwdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign rising      = !r_last && i_in_data.pin_level;
    assign elapsed_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + 1'b1;
    assign timed_out   = elapsed_inc > r_timeout;
    assign sum_add     = r_sum + SUM_W'(div_quo);
    assign sum_shift   = sum_add >> SHIFT;

    always_comb begin
        n_state     = r_state;
        n_last      = r_last;
        n_elapsed   = r_elapsed;
        n_rpm       = r_rpm;
        n_mean      = r_mean;
        n_sum       = r_sum;
        n_phase     = r_phase;
        n_revs      = r_revs;
        n_odo       = r_odo;
        n_to_pend   = r_to_pend;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        div_start   = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_last = i_in_data.pin_level;
                    if (rising) begin
                        n_revs = r_revs + 1'b1;
                        n_odo  = r_odo + DIST_W'(r_step);
                    end
                    n_elapsed = (rising || timed_out) ? '0 : elapsed_inc;
                    if (i_in_data.clear_distance) begin
                        n_revs = '0;
                        n_odo  = '0;
                    end
                    if (rising) begin
                        // rpm and timeout are settled when the quotient is in
                        div_start = 1'b1;
                        n_to_pend = timed_out;
                        n_state   = S_DIV;
                    end else begin
                        if (timed_out) begin
                            n_rpm   = '0;
                            n_mean  = '0;
                            n_sum   = '0;
                            n_phase = '0;
                        end
                        n_out_valid = 1'b1;
                        n_out       = '{n_rpm, n_mean, n_revs, n_odo, 1'b0};
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_rpm = div_quo;
                    if (r_phase == PH_W'(AVERAGE_WINDOW - 1)) begin
                        n_mean  = (|sum_shift[SUM_W-1:RPM_W]) ? '1
                                                              : sum_shift[RPM_W-1:0];
                        n_sum   = '0;
                        n_phase = '0;
                    end else begin
                        n_sum   = sum_add;
                        n_phase = r_phase + 1'b1;
                    end
                    if (r_to_pend) begin
                        n_rpm   = '0;
                        n_mean  = '0;
                        n_sum   = '0;
                        n_phase = '0;
                    end
                    n_out_valid = 1'b1;
                    n_out       = '{n_rpm, n_mean, r_revs, r_odo, 1'b1};
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= 1'b0;
            r_elapsed   <= '0;
            r_rpm       <= '0;
            r_mean      <= '0;
            r_sum       <= '0;
            r_phase     <= '0;
            r_revs      <= '0;
            r_odo       <= '0;
            r_to_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last      <= n_last;
            r_elapsed   <= n_elapsed;
            r_rpm       <= n_rpm;
            r_mean      <= n_mean;
            r_sum       <= n_sum;
            r_phase     <= n_phase;
            r_revs      <= n_revs;
            r_odo       <= n_odo;
            r_to_pend   <= n_to_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== src/tro_checker.sv =====
// Port-level checks for the tachometer top level, attached by bind.
// Depends on tro_pkg for the payload types.
module tro_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [tro_pkg::APB_ADDR_W-1:0]  paddr,
    input logic [tro_pkg::APB_DATA_W-1:0]  pwdata,
    input logic [tro_pkg::APB_DATA_W-1:0]  prdata,
    input logic                            pready,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input tro_pkg::t_in                    i_in_data,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input tro_pkg::t_out                   o_out_data
);
    import tro_pkg::*;

    // a held result blocks new ticks
    a_hold_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input ready while result is stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed or dropped");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable) |-> pready)
        else $error("APB access stalled");

endmodule

bind tachometer_rpm_odometer tro_checker u_tro_checker (.*);
